/* rtl/sarf_pkg.sv */
// ----------------------------------------------------------------------------
// sarf_pkg - shared types and constants for the serial receive FIFO registers
// Register offsets, transaction kinds, character codes and the control and
// status structs passed between the top level and the FIFO cell chain.
// ----------------------------------------------------------------------------
package sarf_pkg;

	localparam int unsigned FIFO_DEPTH = 16;
	localparam int unsigned CNT_W      = $clog2(FIFO_DEPTH + 1);

	localparam logic [1:0] KIND_RX    = 2'd0;
	localparam logic [1:0] KIND_READ  = 2'd1;
	localparam logic [1:0] KIND_WRITE = 2'd2;

	localparam logic [1:0] OFS_DATA = 2'd0;
	localparam logic [1:0] OFS_STAT = 2'd1;
	localparam logic [1:0] OFS_CMD  = 2'd2;
	localparam logic [1:0] OFS_CTRL = 2'd3;

	localparam logic [7:0] STAT_RX_FULL = 8'h08;
	localparam logic [7:0] IDLE_BYTE    = 8'hFF;
	localparam logic [7:0] LF_CODE      = 8'h0A;
	localparam logic [7:0] CR_CODE      = 8'h0D;

	typedef struct packed {
		logic push;
		logic pop;
	} rx_ctrl_t;

	typedef struct packed {
		logic       empty;
		logic [7:0] head;
	} rx_stat_t;

endpackage

/* rtl/serial_acia_receive_fifo_registers.sv */
// ----------------------------------------------------------------------------
// serial_acia_receive_fifo_registers - serial interface registers, RX FIFO
// Each input transaction is a received character, a bus read or a bus write,
// and yields exactly one result transaction. Received characters go into a
// 16-byte FIFO held in a chain of byte cells (oldest dropped when full) and
// raise the interrupt. A data read pops the oldest byte, returns line feed as
// carriage return, gives 0xFF when empty, and clears the interrupt. Status
// reads 0x08 while data is held; command and control read back as written;
// a data write emits a transmit byte. The block takes one transaction per
// cycle; its result appears in the output register on the following cycle.
// The throughput is set by the FIFO chain, which shifts all cells together,
// and by the one-deep output register: input is stalled only while a
// result sits unaccepted and the output side is stalled.
// ----------------------------------------------------------------------------
module serial_acia_receive_fifo_registers
	import sarf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [1:0] kind,
	input  logic [1:0] reg_offset,
	input  logic [7:0] write_value,
	input  logic [7:0] rx_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] read_value,
	output logic       irq_line,
	output logic       tx_valid,
	output logic [7:0] tx_byte
);

	rx_ctrl_t   ctrl;
	rx_stat_t   stat;
	logic       in_fire;
	logic       is_read;
	logic       is_write;
	logic       irq_q;
	logic       irq_next;
	logic [7:0] command_q;
	logic [7:0] control_q;
	logic [7:0] rd_byte;
	logic [7:0] pop_byte;

	logic       out_valid_q;
	logic [7:0] read_value_q;
	logic       irq_line_q;
	logic       tx_valid_q;
	logic [7:0] tx_byte_q;

	// a transaction enters whenever the output register is free or draining
	assign in_stall = out_valid_q && out_stall;
	assign in_fire  = in_valid && !in_stall;

	assign is_read  = (kind == KIND_READ);
	assign is_write = (kind == KIND_WRITE);

	assign ctrl.push = in_fire && (kind == KIND_RX);
	assign ctrl.pop  = in_fire && is_read && (reg_offset == OFS_DATA) && !stat.empty;

	sarf_chain u_chain (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctrl    (ctrl),
		.rx_byte (rx_char),
		.stat    (stat)
	);

	// line feed is handed to the host as carriage return
	assign pop_byte = (stat.head == LF_CODE) ? CR_CODE : stat.head;

	always_comb begin
		rd_byte = IDLE_BYTE;
		if (is_read) begin
			case (reg_offset)
				OFS_DATA: rd_byte = stat.empty ? IDLE_BYTE : pop_byte;
				OFS_STAT: rd_byte = stat.empty ? 8'h00 : STAT_RX_FULL;
				OFS_CMD:  rd_byte = command_q;
				OFS_CTRL: rd_byte = control_q;
				default:  rd_byte = IDLE_BYTE;
			endcase
		end
	end

	// push sets the interrupt, a successful data pop clears it
	always_comb begin
		irq_next = irq_q;
		if (ctrl.push) begin
			irq_next = 1'b1;
		end else if (ctrl.pop) begin
			irq_next = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			irq_q     <= 1'b0;
			command_q <= 8'h00;
			control_q <= 8'h00;
		end else if (in_fire) begin
			irq_q <= irq_next;
			if (is_write && (reg_offset == OFS_CMD)) begin
				command_q <= write_value;
			end
			if (is_write && (reg_offset == OFS_CTRL)) begin
				control_q <= write_value;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			read_value_q <= rd_byte;
			irq_line_q   <= irq_next;
			tx_valid_q   <= is_write && (reg_offset == OFS_DATA);
			tx_byte_q    <= (is_write && (reg_offset == OFS_DATA)) ? write_value : 8'h00;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = read_value_q;
	assign irq_line   = irq_line_q;
	assign tx_valid   = tx_valid_q;
	assign tx_byte    = tx_byte_q;

	// the chain is never popped while it holds nothing
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |-> !stat.empty)
		else $error("FIFO pop while empty");

	// a received character always leaves the interrupt raised in its result
	a_rx_irq: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.push |=> (out_valid_q && irq_line_q))
		else $error("interrupt not raised after receive");

	// a transmit result is never a bus read
	a_tx_not_read: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && tx_valid_q) |-> (read_value_q == IDLE_BYTE))
		else $error("transmit result carries read data");

	// a data pop clears the interrupt, even with bytes left
	a_irq_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.pop |=> !irq_q)
		else $error("interrupt not cleared by data read");

endmodule

/* rtl/sarf_cell.sv */
// ----------------------------------------------------------------------------
// sarf_cell - one byte slot of the receive FIFO chain
// Loads a new character, or takes the byte of its neighbor toward the tail.
// ----------------------------------------------------------------------------
module sarf_cell
	import sarf_pkg::*;
(
	input  logic       clk,
	input  logic       load,
	input  logic       shift,
	input  logic [7:0] new_byte,
	input  logic [7:0] next_byte,
	output logic [7:0] data
);

	logic [7:0] data_q;

	// load wins: the tail cell of a full chain both shifts and loads
	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= new_byte;
		end else if (shift) begin
			data_q <= next_byte;
		end
	end

	assign data = data_q;

endmodule

/* rtl/sarf_chain.sv */
// ----------------------------------------------------------------------------
// sarf_chain - receive FIFO built as a row of shifting byte cells
// Cell 0 holds the oldest byte. A pop moves every byte one cell toward the
// head; a push writes the first free cell, or drops the oldest when full.
// ----------------------------------------------------------------------------
module sarf_chain
	import sarf_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  rx_ctrl_t   ctrl,
	input  logic [7:0] rx_byte,
	output rx_stat_t   stat
);

	logic [CNT_W-1:0] count_q;
	logic [7:0]       cell_data [FIFO_DEPTH];
	logic             full;
	logic             shift;

	assign full  = (count_q == CNT_W'(FIFO_DEPTH));
	assign shift = ctrl.pop || (ctrl.push && full);

	for (genvar i = 0; i < FIFO_DEPTH; i++) begin : g_cell
		logic       load;
		logic [7:0] next_byte;

		if (i == FIFO_DEPTH - 1) begin : g_tail
			assign load      = ctrl.push && (full || (count_q == CNT_W'(i)));
			assign next_byte = 8'h00;
		end else begin : g_body
			assign load      = ctrl.push && !full && (count_q == CNT_W'(i));
			assign next_byte = cell_data[i+1];
		end

		sarf_cell u_cell (
			.clk       (clk),
			.load      (load),
			.shift     (shift),
			.new_byte  (rx_byte),
			.next_byte (next_byte),
			.data      (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.push && !full) begin
			count_q <= count_q + CNT_W'(1);
		end else if (ctrl.pop) begin
			count_q <= count_q - CNT_W'(1);
		end
	end

	assign stat.empty = (count_q == '0);
	assign stat.head  = cell_data[0];

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb - testbench for serial_acia_receive_fifo_registers
// Drives received characters, bus reads and bus writes over the input
// handshake with random gaps, stalls the result side at random, and checks
// every result transaction against a shadow model of the FIFO and registers.
// ----------------------------------------------------------------------------
module tb;
	import sarf_pkg::*;

	// Kind code the block leaves unused; sent as noise.
	localparam logic [1:0] KIND_SPARE = 2'd3;

	// Percentage of cycles in which each side idles outside the calm stretch.
	localparam int unsigned IDLE_PCT = 22;
	localparam int unsigned N_RANDOM = 1000;

	typedef struct packed {
		logic [7:0] read_value;
		logic       irq_line;
		logic       tx_valid;
		logic [7:0] tx_byte;
	} acia_result_t;

	// ------------------------------------------------------------------------
	// Shadow of the FIFO and the registers. Each accepted input transaction
	// queues the result it must produce; result transactions are checked in
	// order against that queue.
	// ------------------------------------------------------------------------
	class acia_shadow;
		logic [7:0]   rx_mem [FIFO_DEPTH];
		int unsigned  rx_head;
		int unsigned  rx_count;
		logic [7:0]   cmd_reg;
		logic [7:0]   ctrl_reg;
		logic         irq;
		acia_result_t awaited[$];
		int unsigned  errors;
		int unsigned  n_items;
		int unsigned  n_pushes;
		int unsigned  n_drops;
		int unsigned  n_pops;
		int unsigned  n_empty_reads;
		int unsigned  n_lf;
		int unsigned  n_tx;

		function new();
			rx_head       = 0;
			rx_count      = 0;
			cmd_reg       = 8'h00;
			ctrl_reg      = 8'h00;
			irq           = 1'b0;
			errors        = 0;
			n_items       = 0;
			n_pushes      = 0;
			n_drops       = 0;
			n_pops        = 0;
			n_empty_reads = 0;
			n_lf          = 0;
			n_tx          = 0;
		endfunction

		function int unsigned outstanding();
			return awaited.size();
		endfunction

		function void take_transaction(logic [1:0] k, logic [1:0] ofs,
				logic [7:0] wval, logic [7:0] rch);
			acia_result_t res;
			int unsigned  tail;
			logic [7:0]   b;
			res.read_value = IDLE_BYTE;
			res.tx_valid   = 1'b0;
			res.tx_byte    = 8'h00;
			n_items++;
			case (k)
				KIND_RX: begin
					// full FIFO: drop the oldest byte to make room
					if (rx_count == FIFO_DEPTH) begin
						rx_head = (rx_head + 1) % FIFO_DEPTH;
						rx_count--;
						n_drops++;
					end
					tail = (rx_head + rx_count) % FIFO_DEPTH;
					rx_mem[tail] = rch;
					rx_count++;
					irq = 1'b1;
					n_pushes++;
				end
				KIND_READ: begin
					case (ofs)
						OFS_DATA: begin
							if (rx_count == 0) begin
								n_empty_reads++;
							end else begin
								b = rx_mem[rx_head];
								rx_head = (rx_head + 1) % FIFO_DEPTH;
								rx_count--;
								irq = 1'b0;
								n_pops++;
								if (b == LF_CODE) begin
									b = CR_CODE;
									n_lf++;
								end
								res.read_value = b;
							end
						end
						OFS_STAT: res.read_value = (rx_count != 0) ? STAT_RX_FULL : 8'h00;
						OFS_CMD:  res.read_value = cmd_reg;
						default:  res.read_value = ctrl_reg;
					endcase
				end
				KIND_WRITE: begin
					case (ofs)
						OFS_DATA: begin
							res.tx_valid = 1'b1;
							res.tx_byte  = wval;
							n_tx++;
						end
						OFS_CMD:  cmd_reg  = wval;
						OFS_CTRL: ctrl_reg = wval;
						default: ;
					endcase
				end
				default: ;
			endcase
			res.irq_line = irq;
			awaited = {awaited, res};
		endfunction

		function void compare_result(acia_result_t got);
			acia_result_t want;
			if (awaited.size() == 0) begin
				$error("result transaction with none outstanding: %h", got);
				errors++;
				return;
			end
			want = awaited[0];
			awaited.delete(0);
			if (got.read_value !== want.read_value) begin
				$error("read_value: expected %02h, actual %02h", want.read_value, got.read_value);
				errors++;
			end
			if (got.irq_line !== want.irq_line) begin
				$error("irq_line: expected %0b, actual %0b", want.irq_line, got.irq_line);
				errors++;
			end
			if (got.tx_valid !== want.tx_valid) begin
				$error("tx_valid: expected %0b, actual %0b", want.tx_valid, got.tx_valid);
				errors++;
			end
			if (got.tx_byte !== want.tx_byte) begin
				$error("tx_byte: expected %02h, actual %02h", want.tx_byte, got.tx_byte);
				errors++;
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, reset and DUT hookup. All inputs start at known values.
	// ------------------------------------------------------------------------
	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic [1:0] kind        = KIND_RX;
	logic [1:0] reg_offset  = OFS_DATA;
	logic [7:0] write_value = 8'h00;
	logic [7:0] rx_char     = 8'h00;
	logic       out_stall   = 1'b0;
	logic       in_stall;
	logic       out_valid;
	logic [7:0] read_value;
	logic       irq_line;
	logic       tx_valid;
	logic [7:0] tx_byte;

	// Set during a stretch of the random phase: neither side idles then.
	logic       calm = 1'b0;
	// Counts transactions that do something; ignored ones are left out.
	int unsigned n_effective = 0;

	acia_shadow shadow = new();

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	serial_acia_receive_fifo_registers DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.kind        (kind),
		.reg_offset  (reg_offset),
		.write_value (write_value),
		.rx_char     (rx_char),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.read_value  (read_value),
		.irq_line    (irq_line),
		.tx_valid    (tx_valid),
		.tx_byte     (tx_byte)
	);

	// ------------------------------------------------------------------------
	// Result side: random stall, updated once per rising edge.
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n)
			out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
	end

	// Outputs are sampled mid-cycle, where nothing changes until the next
	// rising edge; a result transaction completes at that edge.
	always @(negedge clk) begin
		if (arst_n && out_valid && !out_stall)
			shadow.compare_result('{read_value, irq_line, tx_valid, tx_byte});
	end

	// ------------------------------------------------------------------------
	// Input side. Called just after a rising edge; returns just after the edge
	// at which the transaction was accepted, which is when the shadow sees it.
	// ------------------------------------------------------------------------
	task automatic send_item(input logic [1:0] k, input logic [1:0] ofs,
			input logic [7:0] wval, input logic [7:0] rch);
		logic took;
		while (!calm && ($urandom_range(0, 99) < IDLE_PCT)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid    <= 1'b1;
		kind        <= k;
		reg_offset  <= ofs;
		write_value <= wval;
		rx_char     <= rch;
		do begin
			@(negedge clk);
			took = !in_stall;
			@(posedge clk);
		end while (!took);
		shadow.take_transaction(k, ofs, wval, rch);
		// kind 3 and a status write leave the block untouched
		if (k != KIND_SPARE && !(k == KIND_WRITE && ofs == OFS_STAT))
			n_effective++;
	endtask

	// Received character, line feed one time in eight so conversions are common.
	function automatic logic [7:0] pick_char();
		if ($urandom_range(0, 7) == 0)
			return LF_CODE;
		return 8'($urandom_range(0, 255));
	endfunction

	// Holds the input side off until every outstanding result has arrived.
	task automatic drain_outputs();
		in_valid <= 1'b0;
		@(posedge clk);
		while (shadow.outstanding() != 0)
			@(posedge clk);
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		int unsigned choice;
		int unsigned len;
		int unsigned n;
		logic [1:0]  ofs;
		bit          paused;

		paused = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset values, register extremes, ignored transactions,
		// empty-FIFO read, line feed conversion and irq clear with data left.
		send_item(KIND_READ,  OFS_DATA, 8'h00, 8'h00);
		send_item(KIND_READ,  OFS_STAT, 8'h00, 8'h00);
		send_item(KIND_READ,  OFS_CMD,  8'h00, 8'h00);
		send_item(KIND_READ,  OFS_CTRL, 8'h00, 8'h00);
		send_item(KIND_WRITE, OFS_CMD,  8'hFF, 8'h00);
		send_item(KIND_WRITE, OFS_CTRL, 8'h00, 8'hFF);
		send_item(KIND_READ,  OFS_CMD,  8'h00, 8'h00);
		send_item(KIND_READ,  OFS_CTRL, 8'h00, 8'h00);
		send_item(KIND_WRITE, OFS_CTRL, 8'hFF, 8'h00);
		send_item(KIND_WRITE, OFS_CMD,  8'h00, 8'h00);
		send_item(KIND_WRITE, OFS_DATA, 8'h00, 8'h00);
		send_item(KIND_WRITE, OFS_DATA, 8'hFF, 8'hFF);
		send_item(KIND_WRITE, OFS_STAT, 8'hA5, 8'h00);
		send_item(KIND_SPARE, OFS_CTRL, 8'hFF, 8'hFF);
		send_item(KIND_RX,    OFS_DATA, 8'h00, LF_CODE);
		send_item(KIND_RX,    OFS_DATA, 8'h00, 8'hFF);
		send_item(KIND_RX,    OFS_CTRL, 8'hFF, 8'h00);
		send_item(KIND_READ,  OFS_STAT, 8'h00, 8'h00);
		send_item(KIND_READ,  OFS_DATA, 8'h00, 8'h00);
		send_item(KIND_READ,  OFS_DATA, 8'h00, 8'h00);
		send_item(KIND_READ,  OFS_DATA, 8'h00, 8'h00);
		send_item(KIND_READ,  OFS_DATA, 8'h00, 8'h00);
		send_item(KIND_READ,  OFS_STAT, 8'h00, 8'h00);
		send_item(KIND_READ,  OFS_CMD,  8'h00, 8'h00);

		// Random phase built from episodes: character bursts (often past
		// full), drains (often past empty), register traffic, transmit writes
		// and a little noise with any field values at all.
		n = n_effective;
		while (n_effective - n < N_RANDOM) begin
			calm = (n_effective - n >= 300) && (n_effective - n < 450);
			if (!paused && n_effective - n >= 600) begin
				drain_outputs();
				paused = 1'b1;
			end
			choice = $urandom_range(0, 99);
			len    = $urandom_range(1, 20);
			if (choice < 35) begin
				repeat (len)
					send_item(KIND_RX, 2'($urandom_range(0, 3)),
						8'($urandom_range(0, 255)), pick_char());
			end else if (choice < 70) begin
				repeat (len) begin
					ofs = ($urandom_range(0, 3) == 0) ? OFS_STAT : OFS_DATA;
					send_item(KIND_READ, ofs, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
				end
			end else if (choice < 85) begin
				repeat (len % 6 + 1) begin
					ofs = $urandom_range(0, 1) ? OFS_CTRL : OFS_CMD;
					send_item($urandom_range(0, 1) ? KIND_WRITE : KIND_READ, ofs,
						8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				end
			end else if (choice < 93) begin
				repeat (len % 4 + 1)
					send_item(KIND_WRITE, OFS_DATA, 8'($urandom_range(0, 255)),
						8'($urandom_range(0, 255)));
			end else begin
				send_item(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
			end
		end
		calm = 1'b0;
		in_valid <= 1'b0;

		// Let the result side empty and allow for stragglers.
		@(posedge clk);
		while (shadow.outstanding() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Ran %0d transactions: %0d characters in, %0d dropped on overflow, %0d transmit writes.",
			shadow.n_items, shadow.n_pushes, shadow.n_drops, shadow.n_tx);
		$display("Data reads: %0d popped (%0d line feeds turned to CR), %0d on an empty FIFO.",
			shadow.n_pops, shadow.n_lf, shadow.n_empty_reads);
		if (shadow.errors == 0 && shadow.outstanding() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run of this stimulus.
	initial begin
		#1ms;
		$display("Verification failed");
		$finish;
	end

endmodule

/* serial_acia_receive_fifo_registers.f */
rtl/sarf_pkg.sv
rtl/sarf_cell.sv
rtl/sarf_chain.sv
rtl/serial_acia_receive_fifo_registers.sv
tb/tb.sv
